>>> src/psjf_pkg.sv
// Shared types and constants of the preemptive shortest-remaining-time scheduler.
package psjf_pkg;

    localparam int TIME_W = 24;
    localparam int LEN_W  = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  arrival;
        logic [LEN_W-1:0]  burst;
        logic [LEN_W-1:0]  remaining;
        logic [TIME_W-1:0] start;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_FIG,
        ST_RES
    } t_state;

endpackage

>>> src/preemptive_sjf_scheduler.sv
// Top level: preemptive shortest-remaining-time-first scheduler over a job table.
// A load item is written in idle. A tick item scans the table one slot per cycle
// through the single read port of the job memory and one shared comparator, then
// passes an update state, a figure state when the job finishes, and a result state.
// Items are taken only in idle; the result state waits while a result is unaccepted.
// Synchronous active-low reset clears the job flags, the clock and the handshake;
// the job memory holds its contents, which are used only for loaded slots.
module preemptive_sjf_scheduler #(
    parameter int JOBS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [3:0]                    i_slot,
    input  logic [psjf_pkg::LEN_W-1:0]    i_arrival_time,
    input  logic [psjf_pkg::LEN_W-1:0]    i_burst_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3:0]                    o_ran_slot,
    output logic                          o_idle,
    output logic                          o_finished,
    output logic [psjf_pkg::TIME_W-1:0]   o_start_time,
    output logic [psjf_pkg::TIME_W-1:0]   o_completion_time,
    output logic [psjf_pkg::TIME_W-1:0]   o_turnaround_time,
    output logic [psjf_pkg::TIME_W-1:0]   o_waiting_time,
    output logic [psjf_pkg::TIME_W-1:0]   o_response_time,
    output logic                          o_all_done
);
    import psjf_pkg::*;

    localparam int SLOT_W = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int CNT_W  = $clog2(JOBS + 1);
    localparam int EXT_W  = (CNT_W > 4) ? CNT_W : 4;

    t_state r_state, n_state;

    t_job              r_mem [JOBS];
    t_job              r_rd;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_rd_vld;

    logic [JOBS-1:0]   r_loaded, r_started, r_done;
    logic [TIME_W-1:0] r_clock;

    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    t_job              r_best;
    logic [SLOT_W-1:0] r_best_idx;

    logic              r_fin;
    logic [TIME_W-1:0] r_st, r_ct, r_tat, r_rt;

    // control
    logic              in_acc;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_job              mem_wdata;
    logic              out_load;

    logic [EXT_W-1:0]  slot_ext;
    logic              slot_ok;
    logic              cand_elig, cand_better;
    logic [TIME_W-1:0] clk_inc;
    logic              best_last;
    logic [TIME_W-1:0] start_sel;
    logic [TIME_W-1:0] wt;

    assign in_acc    = i_valid && o_ready;
    assign slot_ext  = EXT_W'(i_slot);
    assign slot_ok   = slot_ext < EXT_W'(JOBS);
    assign clk_inc   = (r_clock == TIME_MAX) ? r_clock : r_clock + TIME_W'(1);
    assign best_last = r_best.remaining == LEN_W'(1);
    assign start_sel = r_started[r_best_idx] ? r_best.start : r_clock;
    assign wt        = (r_tat > TIME_W'(r_best.burst)) ? r_tat - TIME_W'(r_best.burst)
                                                       : '0;

    assign cand_elig   = r_rd_vld && r_loaded[r_rd_idx] && !r_done[r_rd_idx]
                         && (TIME_W'(r_rd.arrival) <= r_clock);
    assign cand_better = !r_found || (r_rd.remaining < r_best.remaining)
                         || ((r_rd.remaining == r_best.remaining)
                             && (r_rd.arrival < r_best.arrival));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_kind == KIND_TICK) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == CNT_W'(JOBS) && !r_rd_vld) n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = (r_found && best_last) ? ST_FIG : ST_RES;
            end
            ST_FIG: n_state = ST_RES;
            ST_RES: begin
                if (!o_valid || i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_idx[SLOT_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = slot_ext[SLOT_W-1:0];
        mem_wdata = '{arrival: i_arrival_time, burst: i_burst_length,
                      remaining: i_burst_length, start: '0};
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                mem_we  = in_acc && i_kind == KIND_LOAD && slot_ok;
            end
            ST_SCAN: begin
                rd_en = r_idx < CNT_W'(JOBS);
            end
            ST_UPD: begin
                mem_we    = r_found;
                mem_waddr = r_best_idx;
                mem_wdata = '{arrival: r_best.arrival, burst: r_best.burst,
                              remaining: r_best.remaining - LEN_W'(1), start: start_sel};
            end
            ST_FIG: ;
            ST_RES: begin
                out_load = !o_valid || i_ready;
            end
            default: ;
        endcase
    end

    // job memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (rd_en) r_rd <= r_mem[rd_addr];
        r_rd_idx <= rd_addr;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_loaded  <= '0;
            r_started <= '0;
            r_done    <= '0;
            r_clock   <= '0;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_fin     <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (r_state == ST_IDLE && mem_we) begin
                r_loaded[mem_waddr]  <= 1'b1;
                r_started[mem_waddr] <= 1'b0;
                r_done[mem_waddr]    <= (i_burst_length == '0);
            end
            if (r_state == ST_IDLE && in_acc && i_kind == KIND_TICK) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (rd_en) r_idx <= r_idx + CNT_W'(1);
            if (r_state == ST_SCAN && cand_elig && cand_better) r_found <= 1'b1;
            if (r_state == ST_UPD) begin
                r_clock <= clk_inc;
                r_fin   <= r_found && best_last;
                if (r_found) begin
                    r_started[r_best_idx] <= 1'b1;
                    if (best_last) r_done[r_best_idx] <= 1'b1;
                end
            end
            if (out_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && cand_elig && cand_better) begin
            r_best     <= r_rd;
            r_best_idx <= r_rd_idx;
        end
        if (r_state == ST_UPD) begin
            r_st <= start_sel;
            r_ct <= clk_inc;
        end
        if (r_state == ST_FIG) begin
            r_tat <= r_ct - TIME_W'(r_best.arrival);
            r_rt  <= r_st - TIME_W'(r_best.arrival);
        end
        if (out_load) begin
            o_ran_slot        <= r_found ? 4'(r_best_idx) : 4'd0;
            o_idle            <= !r_found;
            o_finished        <= r_fin;
            o_start_time      <= r_fin ? r_st  : '0;
            o_completion_time <= r_fin ? r_ct  : '0;
            o_turnaround_time <= r_fin ? r_tat : '0;
            o_waiting_time    <= r_fin ? wt    : '0;
            o_response_time   <= r_fin ? r_rt  : '0;
            o_all_done        <= ~|(r_loaded & ~r_done);
        end
    end

    a_idle_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_idle |-> !o_finished)
        else $error("idle result reports a finished job");

    a_clock_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_clock >= $past(r_clock))
        else $error("scheduler clock went backwards");

    a_completion_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_finished |-> o_completion_time >= o_start_time)
        else $error("completion time before start time");

    a_flags_need_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_done | r_started) & ~r_loaded) == '0)
        else $error("done or started flag on an unloaded slot");

endmodule

>>> verif/preemptive_sjf_scheduler_tb.sv
// Self-checking testbench for the preemptive shortest-remaining-time-first scheduler.
module preemptive_sjf_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psjf_pkg::*;

    localparam int JOBS = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET = 450;

    typedef struct packed {
        logic [3:0]        ran_slot;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] response_time;
        logic              all_done;
    } t_tick_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_kind = KIND_LOAD;
    logic [3:0]        i_slot = '0;
    logic [LEN_W-1:0]  i_arrival_time = '0;
    logic [LEN_W-1:0]  i_burst_length = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [3:0]        o_ran_slot;
    logic              o_idle;
    logic              o_finished;
    logic [TIME_W-1:0] o_start_time;
    logic [TIME_W-1:0] o_completion_time;
    logic [TIME_W-1:0] o_turnaround_time;
    logic [TIME_W-1:0] o_waiting_time;
    logic [TIME_W-1:0] o_response_time;
    logic              o_all_done;

    // Shadow of the job table and the scheduler clock
    logic [LEN_W-1:0]  job_arrival_q  [JOBS];
    logic [LEN_W-1:0]  job_burst_q    [JOBS];
    logic [LEN_W-1:0]  job_left_q     [JOBS];
    logic [TIME_W-1:0] job_first_run_q[JOBS];
    bit                job_loaded_q   [JOBS];
    bit                job_started_q  [JOBS];
    bit                job_done_q     [JOBS];
    logic [TIME_W-1:0] sched_clock;

    t_tick_result pending_ticks[$];
    t_tick_result want;

    int fail_count = 0;
    int items_sent = 0;
    int n_loads = 0;
    int n_ticks = 0;
    int n_idle = 0;
    int n_finished = 0;
    int n_results = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    int rx_len;
    bit tx_gap_en = 1'b1;
    bit rx_stall_en = 1'b1;

    preemptive_sjf_scheduler #(
        .JOBS(JOBS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_slot            (i_slot),
        .i_arrival_time    (i_arrival_time),
        .i_burst_length    (i_burst_length),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ran_slot        (o_ran_slot),
        .o_idle            (o_idle),
        .o_finished        (o_finished),
        .o_start_time      (o_start_time),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_response_time   (o_response_time),
        .o_all_done        (o_all_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(bit en);
        int r;
        if (!en) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit table_all_done();
        for (int i = 0; i < JOBS; i++)
            if (job_loaded_q[i] && !job_done_q[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted item to the shadow table; a tick queues its expected result.
    task automatic srtf_step(input logic kind, input logic [3:0] slot,
                             input logic [LEN_W-1:0] arr, input logic [LEN_W-1:0] burst);
        t_tick_result res;
        int pick;
        bit found;
        res = '0;
        pick = 0;
        found = 1'b0;
        if (kind == KIND_LOAD) begin
            n_loads++;
            if (slot < JOBS) begin
                job_arrival_q[slot]   = arr;
                job_burst_q[slot]     = burst;
                job_left_q[slot]      = burst;
                job_first_run_q[slot] = '0;
                job_loaded_q[slot]    = 1'b1;
                job_started_q[slot]   = 1'b0;
                job_done_q[slot]      = (burst == 0);
            end
            return;
        end
        n_ticks++;
        for (int i = 0; i < JOBS; i++) begin
            if (!job_loaded_q[i] || job_done_q[i] || TIME_W'(job_arrival_q[i]) > sched_clock)
                continue;
            if (!found || job_left_q[i] < job_left_q[pick] ||
                (job_left_q[i] == job_left_q[pick] && job_arrival_q[i] < job_arrival_q[pick])) begin
                pick = i;
                found = 1'b1;
            end
        end
        if (found) begin
            if (!job_started_q[pick]) begin
                job_started_q[pick] = 1'b1;
                job_first_run_q[pick] = sched_clock;
            end
            job_left_q[pick] = job_left_q[pick] - 1'b1;
        end
        if (sched_clock != TIME_MAX) sched_clock = sched_clock + 1'b1;
        if (found) begin
            res.ran_slot = 4'(pick);
            if (job_left_q[pick] == 0) begin
                job_done_q[pick] = 1'b1;
                res.finished = 1'b1;
                res.start_time = job_first_run_q[pick];
                res.completion_time = sched_clock;
                res.turnaround_time = sched_clock - TIME_W'(job_arrival_q[pick]);
                // saturates at zero once the clock has stopped counting
                res.waiting_time = (res.turnaround_time > TIME_W'(job_burst_q[pick])) ?
                                   res.turnaround_time - TIME_W'(job_burst_q[pick]) : '0;
                res.response_time = res.start_time - TIME_W'(job_arrival_q[pick]);
                n_finished++;
            end
        end else begin
            res.idle = 1'b1;
            n_idle++;
        end
        res.all_done = table_all_done();
        pending_ticks.push_back(res);
    endtask

    // Valid stays high after acceptance; the next send or a drain decides what follows.
    task automatic send_item(input logic kind, input logic [3:0] slot,
                             input logic [LEN_W-1:0] arr, input logic [LEN_W-1:0] burst);
        int gap;
        gap = pick_gap(tx_gap_en);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_kind = kind;
        i_slot = slot;
        i_arrival_time = arr;
        i_burst_length = burst;
        do @(posedge i_clk); while (!o_ready);
        srtf_step(kind, slot, arr, burst);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_ticks.size() != 0) @(posedge i_clk);
    endtask

    task automatic tick_until_done(input int cap);
        int n;
        n = 0;
        while (!table_all_done() && n < cap) begin
            send_tick();
            n++;
        end
    endtask

    task automatic test_empty_table();
        send_tick();
        send_tick();
        wait_drained();
    endtask

    // Field extremes, reload of a running job, and a zero-length burst.
    task automatic test_field_extremes();
        send_item(KIND_LOAD, 4'd0, 16'h0000, 16'hFFFF);
        send_item(KIND_LOAD, 4'hF, 16'hFFFF, 16'd1);
        send_tick();
        send_tick();
        send_item(KIND_LOAD, 4'd0, 16'h0000, 16'd1);
        send_tick();
        send_item(KIND_LOAD, 4'hF, 16'h0000, 16'd0);
        send_tick();
        wait_drained();
    endtask

    // Tie breaks on arrival then slot, and a short job preempting a longer one.
    task automatic test_ties_and_preemption();
        logic [LEN_W-1:0] now;
        now = LEN_W'(sched_clock);
        send_item(KIND_LOAD, 4'd5, now, 16'd3);
        send_item(KIND_LOAD, 4'd2, now, 16'd3);
        send_item(KIND_LOAD, 4'd9, now - 16'd3, 16'd3);
        send_tick();
        send_item(KIND_LOAD, 4'd7, LEN_W'(sched_clock) + 16'd1, 16'd1);
        tick_until_done(12);
        wait_drained();
    endtask

    function automatic logic [LEN_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return LEN_W'($urandom_range(1, 6));
        if (r < 96) return LEN_W'($urandom_range(7, 40));
        return '0;
    endfunction

    task automatic test_random_traffic();
        int r;
        int k;
        int n;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 3);
            tx_gap_en = (r != 0);
            rx_stall_en = (r != 0);
            if ($urandom_range(0, 9) < 7) begin
                // job set arriving around now, then run it down with late arrivals mixed in
                k = $urandom_range(1, 5);
                repeat (k)
                    send_item(KIND_LOAD, 4'($urandom), LEN_W'(sched_clock) +
                              LEN_W'($urandom_range(0, 8)), pick_burst());
                n = 0;
                while (!table_all_done() && n < 40) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(KIND_LOAD, 4'($urandom), LEN_W'(sched_clock) +
                                  LEN_W'($urandom_range(0, 3)), pick_burst());
                    send_tick();
                    n++;
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        tx_gap_en = 1'b1;
        rx_stall_en = 1'b1;
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready = 1'b0;
        end else begin
            rx_len = pick_gap(rx_stall_en);
            i_ready = (rx_len == 0);
            if (rx_len > 0) rx_hold = rx_len - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_ticks.size() == 0) begin
                $error("result with no tick outstanding: ran_slot %0d", o_ran_slot);
                fail_count++;
            end else begin
                want = pending_ticks.pop_front();
                check_field("ran_slot", want.ran_slot, o_ran_slot);
                check_field("idle", want.idle, o_idle);
                check_field("finished", want.finished, o_finished);
                check_field("start_time", want.start_time, o_start_time);
                check_field("completion_time", want.completion_time, o_completion_time);
                check_field("turnaround_time", want.turnaround_time, o_turnaround_time);
                check_field("waiting_time", want.waiting_time, o_waiting_time);
                check_field("response_time", want.response_time, o_response_time);
                check_field("all_done", want.all_done, o_all_done);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_ticks.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < JOBS; i++) begin
            job_loaded_q[i] = 1'b0;
            job_started_q[i] = 1'b0;
            job_done_q[i] = 1'b0;
        end
        sched_clock = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_field_extremes();
        test_ties_and_preemption();
        test_random_traffic();

        repeat (40) @(posedge i_clk);
        if (pending_ticks.size() != 0) begin
            $error("%0d expected results never arrived", pending_ticks.size());
            fail_count++;
        end
        $display("Run: %0d items (%0d loads, %0d ticks), %0d results checked",
                 items_sent, n_loads, n_ticks, n_results);
        $display("Schedule: %0d jobs completed, %0d idle ticks, final clock %0d",
                 n_finished, n_idle, sched_clock);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
